// File: design/tmsn_pkg.sv
// ----------------------------------------------------------------------------
// Trimmed mean sensor normalizer package
// Shared widths, payload structs, control structs, state codes and helpers.
// ----------------------------------------------------------------------------
package tmsn_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int CFG_BITS     = 12;
    localparam int LEVEL_BITS   = 8;
    localparam int QUOT_BITS    = 8;
    localparam int CHANNELS     = 5;
    localparam int ROUNDS_DEF   = 5;
    localparam int LEVEL_SPAN   = 100;
    localparam int LEVEL_MAX    = 155;
    localparam int CFG_IDX_BITS = 3;

    typedef logic [SAMPLE_BITS-1:0]  sample_t;
    typedef logic [CFG_BITS-1:0]     cfg_word_t;
    typedef logic [LEVEL_BITS-1:0]   level_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_index_t;

    typedef sample_t [CHANNELS-1:0]   tmsn_round_t;
    typedef level_t [CHANNELS-1:0]    level_vec_t;
    typedef cfg_word_t [CHANNELS-1:0] floor_vec_t;

    localparam cfg_word_t FULL_SCALE_RESET = cfg_word_t'(4095);

    localparam cfg_index_t REG_FULL_SCALE       = cfg_index_t'(0);
    localparam cfg_index_t REG_FAR_RIGHT_FLOOR  = cfg_index_t'(1);
    localparam cfg_index_t REG_NEAR_RIGHT_FLOOR = cfg_index_t'(2);
    localparam cfg_index_t REG_MIDDLE_FLOOR     = cfg_index_t'(3);
    localparam cfg_index_t REG_NEAR_LEFT_FLOOR  = cfg_index_t'(4);
    localparam cfg_index_t REG_FAR_LEFT_FLOOR   = cfg_index_t'(5);

    typedef struct packed {
        sample_t far_right_raw;
        sample_t near_right_raw;
        sample_t middle_raw;
        sample_t near_left_raw;
        sample_t far_left_raw;
    } tmsn_in_t;

    typedef struct packed {
        level_t far_right_level;
        level_t near_right_level;
        level_t middle_level;
        level_t near_left_level;
        level_t far_left_level;
    } tmsn_out_t;

    typedef struct packed {
        logic fill;
        logic rotate;
    } tmsn_cell_ctrl_t;

    typedef struct packed {
        logic scan;
        logic scan_first;
        logic prep_span;
        logic prep_num;
        logic divide;
    } tmsn_lane_ctrl_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_SCAN,
        ST_PREP_SPAN,
        ST_PREP_NUM,
        ST_DIVIDE,
        ST_DONE
    } tmsn_state_t;

    function automatic tmsn_round_t round_from_in(input tmsn_in_t d);
        tmsn_round_t r;
        r[0] = d.far_right_raw;
        r[1] = d.near_right_raw;
        r[2] = d.middle_raw;
        r[3] = d.near_left_raw;
        r[4] = d.far_left_raw;
        return r;
    endfunction

    function automatic tmsn_out_t out_from_levels(input level_vec_t lv);
        tmsn_out_t o;
        o.far_right_level  = lv[0];
        o.near_right_level = lv[1];
        o.middle_level     = lv[2];
        o.near_left_level  = lv[3];
        o.far_left_level   = lv[4];
        return o;
    endfunction

endpackage

// File: design/tmsn_cell.sv
// ----------------------------------------------------------------------------
// Round cell
// Holds one round of readings; loads a new round or the neighbor's round.
// ----------------------------------------------------------------------------
module tmsn_cell (
    input  logic                      aclk,
    input  tmsn_pkg::tmsn_cell_ctrl_t ctrl,
    input  tmsn_pkg::tmsn_round_t     fill_in,
    input  tmsn_pkg::tmsn_round_t     ring_in,
    output tmsn_pkg::tmsn_round_t     round_q
);
    import tmsn_pkg::*;

    tmsn_round_t round_reg;
    tmsn_round_t round_next;

    always_comb begin
        round_next = round_reg;
        if (ctrl.fill) begin
            round_next = fill_in;
        end else if (ctrl.rotate) begin
            round_next = ring_in;
        end
    end

    always_ff @(posedge aclk) begin
        round_reg <= round_next;
    end

    assign round_q = round_reg;

endmodule

// File: design/tmsn_lane.sv
// ----------------------------------------------------------------------------
// Channel lane
// Gathers sum, minimum and maximum of one channel as the rounds pass by,
// then forms the scaled numerator and runs a restoring divide.
// ----------------------------------------------------------------------------
module tmsn_lane #(
    parameter int ROUNDS = tmsn_pkg::ROUNDS_DEF
) (
    input  logic                      aclk,
    input  tmsn_pkg::tmsn_lane_ctrl_t ctrl,
    input  tmsn_pkg::sample_t         sample,
    input  tmsn_pkg::cfg_word_t       full_scale,
    input  tmsn_pkg::cfg_word_t       floor_value,
    output tmsn_pkg::level_t          level
);
    import tmsn_pkg::*;

    localparam int M      = ROUNDS - 2;
    localparam int M_BITS = $clog2(M + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(ROUNDS);
    localparam int MFS_W  = CFG_BITS + M_BITS;
    localparam int DIFF_W = (SUM_W > MFS_W) ? SUM_W : MFS_W;
    localparam int NUM_W  = DIFF_W + 7;
    localparam int DIV_W  = MFS_W;

    logic [SUM_W-1:0]     sum_reg, sum_next;
    sample_t              min_reg, min_next;
    sample_t              max_reg, max_next;
    logic [DIFF_W-1:0]    trim_reg, trim_next;
    logic [DIFF_W-1:0]    mfs_reg, mfs_next;
    logic [DIV_W-1:0]     div_reg, div_next;
    logic                 degen_reg, degen_next;
    logic                 zero_reg, zero_next;
    logic                 sat_reg, sat_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     div_sh_reg, div_sh_next;
    logic [QUOT_BITS-1:0] quot_reg, quot_next;

    cfg_word_t            span;
    logic [NUM_W-1:0]     num_prod;
    logic [NUM_W:0]       sat_limit;

    assign span      = full_scale - floor_value;
    assign num_prod  = NUM_W'(mfs_reg - trim_reg) * NUM_W'(LEVEL_SPAN);
    assign sat_limit = (NUM_W + 1)'(div_reg) * (NUM_W + 1)'(LEVEL_MAX + 1);

    always_comb begin
        sum_next    = sum_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        trim_next   = trim_reg;
        mfs_next    = mfs_reg;
        div_next    = div_reg;
        degen_next  = degen_reg;
        zero_next   = zero_reg;
        sat_next    = sat_reg;
        rem_next    = rem_reg;
        div_sh_next = div_sh_reg;
        quot_next   = quot_reg;
        if (ctrl.scan) begin
            if (ctrl.scan_first) begin
                sum_next = SUM_W'(sample);
                min_next = sample;
                max_next = sample;
            end else begin
                sum_next = sum_reg + SUM_W'(sample);
                if (sample < min_reg) begin
                    min_next = sample;
                end
                if (sample > max_reg) begin
                    max_next = sample;
                end
            end
        end
        if (ctrl.prep_span) begin
            trim_next  = DIFF_W'(sum_reg - SUM_W'(min_reg) - SUM_W'(max_reg));
            mfs_next   = DIFF_W'(MFS_W'(full_scale) * MFS_W'(M));
            div_next   = DIV_W'(span) * DIV_W'(M);
            degen_next = (full_scale <= floor_value);
        end
        if (ctrl.prep_num) begin
            zero_next   = degen_reg || (trim_reg > mfs_reg);
            rem_next    = num_prod;
            sat_next    = ({1'b0, num_prod} >= sat_limit);
            div_sh_next = NUM_W'(div_reg) << (QUOT_BITS - 1);
            quot_next   = '0;
        end
        if (ctrl.divide) begin
            if (rem_reg >= div_sh_reg) begin
                rem_next  = rem_reg - div_sh_reg;
                quot_next = {quot_reg[QUOT_BITS-2:0], 1'b1};
            end else begin
                quot_next = {quot_reg[QUOT_BITS-2:0], 1'b0};
            end
            div_sh_next = div_sh_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        trim_reg   <= trim_next;
        mfs_reg    <= mfs_next;
        div_reg    <= div_next;
        degen_reg  <= degen_next;
        zero_reg   <= zero_next;
        sat_reg    <= sat_next;
        rem_reg    <= rem_next;
        div_sh_reg <= div_sh_next;
        quot_reg   <= quot_next;
    end

    assign level = zero_reg ? '0 :
                   sat_reg  ? LEVEL_BITS'(LEVEL_MAX) : LEVEL_BITS'(quot_reg);

endmodule

// File: design/trimmed_mean_sensor_normalizer_top.sv
// ----------------------------------------------------------------------------
// Sequence: a round that does not complete a batch is simply stored.
// The round that completes a batch starts the reduction: ROUNDS rotate steps,
// two setup steps, eight divide steps and one output load; the next round is
// taken in the cycle after the load, or later on stall.
// No new round is taken until the batch result is loaded.
// Reset: control state clears, configuration takes its defaults, cells do not.
// ----------------------------------------------------------------------------
// Trimmed mean sensor normalizer
// Collects rounds of five readings in a chain of cells and emits, per batch,
// each channel's trimmed mean mapped to a level between 0 and 155.
// ----------------------------------------------------------------------------
module trimmed_mean_sensor_normalizer_top #(
    parameter int ROUNDS = tmsn_pkg::ROUNDS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tmsn_pkg::tmsn_in_t     s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tmsn_pkg::tmsn_out_t    m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  tmsn_pkg::cfg_index_t   cfg_index,
    input  tmsn_pkg::cfg_word_t    cfg_data
);
    import tmsn_pkg::*;

    localparam int RC_W   = $clog2(ROUNDS);
    localparam int STEP_W = $clog2((ROUNDS > QUOT_BITS) ? ROUNDS : QUOT_BITS);

    tmsn_state_t       state_reg, state_next;
    logic [RC_W-1:0]   round_reg, round_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    tmsn_out_t         m_data_reg;
    cfg_word_t         full_scale_reg;
    floor_vec_t        floor_reg;

    tmsn_cell_ctrl_t   cell_ctrl;
    tmsn_lane_ctrl_t   lane_ctrl;
    logic              load_out;
    logic              s_fire;
    tmsn_round_t       s_round;
    tmsn_round_t       cell_q [ROUNDS];
    level_vec_t        lane_level;

    assign s_fire    = s_valid && s_ready;
    assign s_round   = round_from_in(s_data);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_scale_reg <= FULL_SCALE_RESET;
            floor_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FULL_SCALE:       full_scale_reg <= cfg_data;
                REG_FAR_RIGHT_FLOOR:  floor_reg[0]   <= cfg_data;
                REG_NEAR_RIGHT_FLOOR: floor_reg[1]   <= cfg_data;
                REG_MIDDLE_FLOOR:     floor_reg[2]   <= cfg_data;
                REG_NEAR_LEFT_FLOOR:  floor_reg[3]   <= cfg_data;
                REG_FAR_LEFT_FLOOR:   floor_reg[4]   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            round_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        step_next    = step_reg;
        s_ready      = 1'b0;
        load_out     = 1'b0;
        cell_ctrl    = '0;
        lane_ctrl    = '0;
        case (state_reg)
            ST_COLLECT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cell_ctrl.fill = 1'b1;
                    if (round_reg == RC_W'(ROUNDS - 1)) begin
                        round_next = '0;
                        step_next  = '0;
                        state_next = ST_SCAN;
                    end else begin
                        round_next = round_reg + 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cell_ctrl.rotate     = 1'b1;
                lane_ctrl.scan       = 1'b1;
                lane_ctrl.scan_first = (step_reg == '0);
                step_next            = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROUNDS - 1)) begin
                    state_next = ST_PREP_SPAN;
                end
            end
            ST_PREP_SPAN: begin
                lane_ctrl.prep_span = 1'b1;
                state_next          = ST_PREP_NUM;
            end
            ST_PREP_NUM: begin
                lane_ctrl.prep_num = 1'b1;
                step_next          = '0;
                state_next         = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                lane_ctrl.divide = 1'b1;
                step_next        = step_reg + 1'b1;
                if (step_reg == STEP_W'(QUOT_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= out_from_levels(lane_level);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    genvar k;
    generate
        for (k = 0; k < ROUNDS; k++) begin : g_cell
            if (k == 0) begin : g_head
                tmsn_cell u_cell (
                    .aclk    (aclk),
                    .ctrl    (cell_ctrl),
                    .fill_in (s_round),
                    .ring_in (cell_q[ROUNDS-1]),
                    .round_q (cell_q[k])
                );
            end else begin : g_body
                tmsn_cell u_cell (
                    .aclk    (aclk),
                    .ctrl    (cell_ctrl),
                    .fill_in (cell_q[k-1]),
                    .ring_in (cell_q[k-1]),
                    .round_q (cell_q[k])
                );
            end
        end
        for (k = 0; k < CHANNELS; k++) begin : g_lane
            tmsn_lane #(
                .ROUNDS (ROUNDS)
            ) u_lane (
                .aclk        (aclk),
                .ctrl        (lane_ctrl),
                .sample      (cell_q[ROUNDS-1][k]),
                .full_scale  (full_scale_reg),
                .floor_value (floor_reg[k]),
                .level       (lane_level[k])
            );
        end
    endgenerate

`ifndef SYNTH
    a_last_round_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && round_reg == RC_W'(ROUNDS - 1)) |=> (state_reg == ST_SCAN))
        else $error("final round transfer did not start the scan");

    a_divide_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE && step_reg == STEP_W'(QUOT_BITS - 1))
        |=> (state_reg == ST_DONE))
        else $error("divide did not end after the last quotient bit");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished batch");
`endif

endmodule
